// ===== rtl/narp_pkg.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Note arpeggiator package
// Shared beat types, command and register codes, and control types.
// ----------------------------------------------------------------------------
package narp_pkg;

    // Command codes on the input channel.
    localparam logic [2:0] CMD_NOTE_ON     = 3'd0;
    localparam logic [2:0] CMD_NOTE_OFF    = 3'd1;
    localparam logic [2:0] CMD_ALL_OFF     = 3'd2;
    localparam logic [2:0] CMD_MIDI_CLOCK  = 3'd3;
    localparam logic [2:0] CMD_SAMPLE_TICK = 3'd4;

    // Configuration register indexes.
    localparam logic [2:0] CFG_ARP_ENABLE   = 3'd0;
    localparam logic [2:0] CFG_LATCH_ON     = 3'd1;
    localparam logic [2:0] CFG_ORDER_MODE   = 3'd2;
    localparam logic [2:0] CFG_OCTAVE_RANGE = 3'd3;
    localparam logic [2:0] CFG_CLOCK_SELECT = 3'd4;
    localparam logic [2:0] CFG_STEP_PERIOD  = 3'd5;

    // Clock select codes that matter to the datapath.
    localparam logic [2:0] CLK_SEL_HALF     = 3'd1;
    localparam logic [2:0] CLK_SEL_DOUBLE   = 3'd3;
    localparam logic [2:0] CLK_SEL_MIDI_3   = 3'd4;
    localparam logic [2:0] CLK_SEL_MIDI_12  = 3'd6;

    localparam int          LATCH_MAX       = 64;
    localparam logic [27:0] ONE_SAMPLE      = 28'd512;
    localparam logic [25:0] STEP_PERIOD_RST = 26'd24000;

    typedef struct packed {
        logic [2:0] command;
        logic [6:0] note_number;
    } in_beat_t;

    typedef struct packed {
        logic signed [8:0] active_note;
        logic              step_fired;
    } out_beat_t;

    typedef struct packed {
        logic        arp_enable;
        logic        latch_on;
        logic        order_mode;
        logic [1:0]  octave_range;
        logic [2:0]  clock_select;
        logic [25:0] step_period;
    } cfg_t;

    typedef enum logic [2:0] {
        OP_NOTE_ON,
        OP_NOTE_OFF,
        OP_ALL_OFF,
        OP_MIDI_CLOCK,
        OP_SAMPLE_TICK,
        OP_NONE
    } op_t;

    typedef struct packed {
        op_t        op;
        logic [6:0] note;
    } item_t;

    // Head of the front queue as seen by the back end.
    typedef struct packed {
        logic  valid;
        item_t item;
    } fe_head_t;

    typedef enum logic [4:0] {
        S_IDLE,
        S_DECODE,
        S_SCAN_RD,
        S_SCAN_CMP,
        S_APPEND,
        S_OFF_RD,
        S_OFF_CMP,
        S_OFF_END,
        S_RB_INIT,
        S_RB_RD,
        S_RB_GET,
        S_INS_CHK,
        S_INS_CMP,
        S_INS_WR,
        S_RB_END,
        S_NN_START,
        S_NN_MOD,
        S_NN_RD,
        S_NN_GET,
        S_TAIL
    } bk_state_t;

    // Semitone offset of an octave copy.
    function automatic logic [7:0] octave_offset(input logic [1:0] oct);
        logic [7:0] off;
        case (oct)
            2'd0:    off = 8'd0;
            2'd1:    off = 8'd12;
            2'd2:    off = 8'd24;
            default: off = 8'd36;
        endcase
        return off;
    endfunction

endpackage

// ===== rtl/narp_stream_if.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Note arpeggiator stream interface
// Valid/ready channel carrying one payload beat.
// ----------------------------------------------------------------------------
interface narp_stream_if #(parameter type payload_t = logic) ();
    logic     valid;
    logic     ready;
    payload_t payload;

    modport source (output valid, output payload, input ready);
    modport sink   (input valid, input payload, output ready);
endinterface

// ===== rtl/narp_ram.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Note arpeggiator generic RAM
// One write port and one read port with registered read data.
// ----------------------------------------------------------------------------
module narp_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 64
) (
    input  logic                                       clk,
    input  logic                                       we,
    input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] waddr,
    input  logic [WIDTH-1:0]                           wdata,
    input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] raddr,
    output logic [WIDTH-1:0]                           rdata
);
    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rd_reg;

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rd_reg <= mem[raddr];
    end

    assign rdata = rd_reg;
endmodule

// ===== rtl/narp_front.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Note arpeggiator front end
// Accepts input beats, classifies the command and queues up to two items.
// ----------------------------------------------------------------------------
module narp_front (
    input  logic               clk,
    input  logic               rst_n,
    narp_stream_if.sink        notes,
    input  logic               pop,
    output narp_pkg::fe_head_t head
);
    import narp_pkg::*;

    item_t      q_reg [2];
    logic       wr_ptr_reg;
    logic       rd_ptr_reg;
    logic [1:0] count_reg;
    item_t      item_in;
    logic       push;
    logic       take;

    always_comb
    begin
        case (notes.payload.command)
            CMD_NOTE_ON:     item_in.op = OP_NOTE_ON;
            CMD_NOTE_OFF:    item_in.op = OP_NOTE_OFF;
            CMD_ALL_OFF:     item_in.op = OP_ALL_OFF;
            CMD_MIDI_CLOCK:  item_in.op = OP_MIDI_CLOCK;
            CMD_SAMPLE_TICK: item_in.op = OP_SAMPLE_TICK;
            default:         item_in.op = OP_NONE;
        endcase
        item_in.note = notes.payload.note_number;
    end

    assign notes.ready = (count_reg != 2'd2);
    assign push        = notes.valid && notes.ready;
    assign take        = pop && (count_reg != 2'd0);

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            q_reg[wr_ptr_reg] <= item_in;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= 1'b0;
            rd_ptr_reg <= 1'b0;
            count_reg  <= 2'd0;
        end
        else
        begin
            if (push)
            begin
                wr_ptr_reg <= !wr_ptr_reg;
            end
            if (take)
            begin
                rd_ptr_reg <= !rd_ptr_reg;
            end
            count_reg <= count_reg + {1'b0, push} - {1'b0, take};
        end
    end

    assign head.valid = (count_reg != 2'd0);
    assign head.item  = q_reg[rd_ptr_reg];
endmodule

// ===== rtl/narp_back.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Note arpeggiator back end
// Runs note list updates, sequence rebuilds, clocks and the step walk.
// ----------------------------------------------------------------------------
module narp_back #(
    parameter int NOTE_SLOTS = 64
) (
    input  logic               clk,
    input  logic               rst_n,
    input  narp_pkg::fe_head_t head,
    output logic               pop,
    input  narp_pkg::cfg_t     cfg,
    narp_stream_if.source      results
);
    import narp_pkg::*;

    localparam int SEQ_MAX = ((NOTE_SLOTS > LATCH_MAX) ? NOTE_SLOTS : LATCH_MAX) * 4;
    localparam int SL_W    = $clog2(SEQ_MAX + 1);
    localparam int SA_W    = $clog2(SEQ_MAX);
    localparam int HC_W    = $clog2(NOTE_SLOTS + 1);
    localparam int HA_W    = (NOTE_SLOTS > 1) ? $clog2(NOTE_SLOTS) : 1;
    localparam int LA_W    = $clog2(LATCH_MAX);

    bk_state_t state_reg, state_next;

    op_t               op_reg;
    logic [6:0]        note_reg;
    logic [HC_W-1:0]   held_cnt_reg;
    logic [6:0]        latch_cnt_reg;
    logic [SL_W-1:0]   seq_len_reg;
    logic [SL_W-1:0]   pos_reg;
    logic              asc_reg;
    logic signed [8:0] cur_reg;
    logic [3:0]        pulse_reg;
    logic [27:0]       accum_reg;
    logic [SL_W-1:0]   idx_reg;
    logic [SL_W-1:0]   wr_reg;
    logic              found_reg;
    logic [1:0]        oct_reg;
    logic [1:0]        octs_reg;
    logic [SL_W-1:0]   src_n_reg;
    logic [7:0]        ins_val_reg;
    logic [SL_W-1:0]   ins_pos_reg;
    logic [SL_W-1:0]   mod_reg;
    logic              fired_reg;
    logic              out_valid_reg;
    out_beat_t         out_beat_reg;

    // Memory ports.
    logic            held_we, latch_we, seq_we;
    logic [HA_W-1:0] held_waddr, held_raddr;
    logic [6:0]      held_wdata, held_rdata;
    logic [LA_W-1:0] latch_waddr, latch_raddr;
    logic [6:0]      latch_wdata, latch_rdata;
    logic [SA_W-1:0] seq_waddr, seq_raddr;
    logic [7:0]      seq_wdata, seq_rdata;

    // Datapath helpers.
    logic [SL_W-1:0]   held_cnt_ext;
    logic [SL_W-1:0]   idx_inc;
    logic [SL_W-1:0]   ins_prev;
    logic [SL_W-1:0]   rb_n;
    logic [1:0]        rb_octs;
    logic [6:0]        src_data;
    logic [7:0]        oct_val;
    logic              rb_last;
    logic [27:0]       eff_per;
    logic [28:0]       tick_sum;
    logic              tick_en;
    logic              tick_hit;
    logic [3:0]        pulse_inc;
    logic [3:0]        pulse_div;
    logic              midi_en;
    logic              midi_hit;
    logic              out_free;
    logic signed [8:0] act;

    assign held_cnt_ext = SL_W'(held_cnt_reg);
    assign idx_inc      = idx_reg + SL_W'(1);
    assign ins_prev     = ins_pos_reg - SL_W'(1);
    assign rb_n         = cfg.latch_on ? SL_W'(latch_cnt_reg) : held_cnt_ext;
    assign src_data     = cfg.latch_on ? latch_rdata : held_rdata;
    assign oct_val      = {1'b0, src_data} + octave_offset(oct_reg);
    assign rb_last      = (idx_inc >= src_n_reg) && (oct_reg == octs_reg);

    always_comb
    begin
        case (cfg.octave_range)
            2'd0:    rb_octs = 2'd0;
            2'd1:    rb_octs = 2'd1;
            default: rb_octs = 2'd3;
        endcase
    end

    // Internal sample clock: the accumulator counts 1/512 sample.
    always_comb
    begin
        if (cfg.clock_select == CLK_SEL_HALF)
        begin
            eff_per = {2'b00, cfg.step_period};
        end
        else if (cfg.clock_select == CLK_SEL_DOUBLE)
        begin
            eff_per = {cfg.step_period, 2'b00};
        end
        else
        begin
            eff_per = {1'b0, cfg.step_period, 1'b0};
        end
        if (eff_per < ONE_SAMPLE)
        begin
            eff_per = ONE_SAMPLE;
        end
    end

    assign tick_sum = {1'b0, accum_reg} + {1'b0, ONE_SAMPLE};
    assign tick_en  = cfg.arp_enable && (seq_len_reg != '0) && (cfg.clock_select < CLK_SEL_MIDI_3);
    assign tick_hit = tick_sum >= {1'b0, eff_per};

    always_comb
    begin
        if (cfg.clock_select == CLK_SEL_MIDI_3)
        begin
            pulse_div = 4'd3;
        end
        else if (cfg.clock_select == CLK_SEL_MIDI_12)
        begin
            pulse_div = 4'd12;
        end
        else
        begin
            pulse_div = 4'd6;
        end
    end

    assign pulse_inc = pulse_reg + 4'd1;
    assign midi_en   = cfg.clock_select >= CLK_SEL_MIDI_3;
    assign midi_hit  = midi_en && (pulse_inc >= pulse_div);
    assign out_free  = !out_valid_reg || results.ready;
    assign act       = (cfg.arp_enable && (seq_len_reg != '0)) ? cur_reg : -9'sd1;

    // Next state.
    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            S_IDLE:
            begin
                if (head.valid)
                begin
                    state_next = S_DECODE;
                end
            end
            S_DECODE:
            begin
                case (op_reg)
                    OP_NOTE_ON:
                    begin
                        if (cfg.latch_on || (held_cnt_reg == '0))
                        begin
                            state_next = S_APPEND;
                        end
                        else
                        begin
                            state_next = S_SCAN_RD;
                        end
                    end
                    OP_NOTE_OFF:
                    begin
                        if (cfg.latch_on)
                        begin
                            state_next = S_TAIL;
                        end
                        else if (held_cnt_reg == '0)
                        begin
                            state_next = S_OFF_END;
                        end
                        else
                        begin
                            state_next = S_OFF_RD;
                        end
                    end
                    OP_MIDI_CLOCK:  state_next = midi_hit ? S_NN_START : S_TAIL;
                    OP_SAMPLE_TICK: state_next = (tick_en && tick_hit) ? S_NN_START : S_TAIL;
                    default:        state_next = S_TAIL;
                endcase
            end
            S_SCAN_RD:  state_next = S_SCAN_CMP;
            S_SCAN_CMP: state_next = (idx_inc < held_cnt_ext) ? S_SCAN_RD : S_APPEND;
            S_APPEND:   state_next = S_RB_INIT;
            S_OFF_RD:   state_next = S_OFF_CMP;
            S_OFF_CMP:  state_next = (idx_inc < held_cnt_ext) ? S_OFF_RD : S_OFF_END;
            S_OFF_END:  state_next = S_RB_INIT;
            S_RB_INIT:  state_next = (rb_n == '0) ? S_RB_END : S_RB_RD;
            S_RB_RD:    state_next = S_RB_GET;
            S_RB_GET:
            begin
                if (!cfg.order_mode)
                begin
                    state_next = S_INS_CHK;
                end
                else
                begin
                    state_next = rb_last ? S_RB_END : S_RB_RD;
                end
            end
            S_INS_CHK:  state_next = (ins_pos_reg == '0) ? S_INS_WR : S_INS_CMP;
            S_INS_CMP:  state_next = (seq_rdata > ins_val_reg) ? S_INS_CHK : S_INS_WR;
            S_INS_WR:   state_next = rb_last ? S_RB_END : S_RB_RD;
            S_RB_END:   state_next = S_TAIL;
            S_NN_START: state_next = (seq_len_reg == '0) ? S_TAIL : S_NN_MOD;
            S_NN_MOD:   state_next = (mod_reg >= seq_len_reg) ? S_NN_MOD : S_NN_RD;
            S_NN_RD:    state_next = S_NN_GET;
            S_NN_GET:   state_next = S_TAIL;
            S_TAIL:     state_next = out_free ? S_IDLE : S_TAIL;
            default:    state_next = S_IDLE;
        endcase
    end

    // Memory controls and queue pop.
    always_comb
    begin
        pop         = (state_reg == S_IDLE) && head.valid;
        held_we     = 1'b0;
        held_waddr  = held_cnt_reg[HA_W-1:0];
        held_wdata  = note_reg;
        held_raddr  = idx_reg[HA_W-1:0];
        latch_we    = 1'b0;
        latch_waddr = latch_cnt_reg[LA_W-1:0];
        latch_wdata = note_reg;
        latch_raddr = idx_reg[LA_W-1:0];
        seq_we      = 1'b0;
        seq_waddr   = ins_pos_reg[SA_W-1:0];
        seq_wdata   = ins_val_reg;
        seq_raddr   = (state_reg == S_INS_CHK) ? ins_prev[SA_W-1:0] : mod_reg[SA_W-1:0];
        case (state_reg)
            S_APPEND:
            begin
                if (cfg.latch_on)
                begin
                    latch_we = latch_cnt_reg < 7'(LATCH_MAX);
                end
                else
                begin
                    held_we = !found_reg && (held_cnt_reg < HC_W'(NOTE_SLOTS));
                end
            end
            S_OFF_CMP:
            begin
                held_we    = held_rdata != note_reg;
                held_waddr = wr_reg[HA_W-1:0];
                held_wdata = held_rdata;
            end
            S_RB_GET:
            begin
                seq_we    = cfg.order_mode;
                seq_waddr = seq_len_reg[SA_W-1:0];
                seq_wdata = oct_val;
            end
            S_INS_CMP:
            begin
                seq_we    = seq_rdata > ins_val_reg;
                seq_wdata = seq_rdata;
            end
            S_INS_WR:
            begin
                seq_we = 1'b1;
            end
            default:
            begin
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    // Payload-only registers.
    always_ff @(posedge clk)
    begin
        case (state_reg)
            S_IDLE:
            begin
                op_reg   <= head.item.op;
                note_reg <= head.item.note;
            end
            S_RB_INIT:
            begin
                src_n_reg <= rb_n;
                octs_reg  <= rb_octs;
            end
            S_RB_GET:
            begin
                ins_val_reg <= oct_val;
            end
            default:
            begin
            end
        endcase
    end

    // Control and arpeggio state.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            held_cnt_reg  <= '0;
            latch_cnt_reg <= '0;
            seq_len_reg   <= '0;
            pos_reg       <= '0;
            asc_reg       <= 1'b1;
            cur_reg       <= -9'sd1;
            pulse_reg     <= '0;
            accum_reg     <= '0;
            idx_reg       <= '0;
            wr_reg        <= '0;
            found_reg     <= 1'b0;
            oct_reg       <= '0;
            ins_pos_reg   <= '0;
            mod_reg       <= '0;
            fired_reg     <= 1'b0;
        end
        else
        begin
            case (state_reg)
                S_IDLE:
                begin
                    fired_reg <= 1'b0;
                end
                S_DECODE:
                begin
                    idx_reg   <= '0;
                    wr_reg    <= '0;
                    found_reg <= 1'b0;
                    mod_reg   <= pos_reg;
                    case (op_reg)
                        OP_ALL_OFF:
                        begin
                            held_cnt_reg  <= '0;
                            latch_cnt_reg <= '0;
                            seq_len_reg   <= '0;
                            cur_reg       <= -9'sd1;
                            pos_reg       <= '0;
                            pulse_reg     <= '0;
                        end
                        OP_MIDI_CLOCK:
                        begin
                            if (midi_en)
                            begin
                                pulse_reg <= midi_hit ? 4'd0 : pulse_inc;
                            end
                        end
                        OP_SAMPLE_TICK:
                        begin
                            if (tick_en)
                            begin
                                if (tick_hit)
                                begin
                                    accum_reg <= 28'(tick_sum - {1'b0, eff_per});
                                    fired_reg <= 1'b1;
                                end
                                else
                                begin
                                    accum_reg <= tick_sum[27:0];
                                end
                            end
                        end
                        default:
                        begin
                        end
                    endcase
                end
                S_SCAN_CMP:
                begin
                    if (held_rdata == note_reg)
                    begin
                        found_reg <= 1'b1;
                    end
                    idx_reg <= idx_inc;
                end
                S_APPEND:
                begin
                    if (latch_we)
                    begin
                        latch_cnt_reg <= latch_cnt_reg + 7'd1;
                    end
                    if (held_we)
                    begin
                        held_cnt_reg <= held_cnt_reg + HC_W'(1);
                    end
                    pos_reg <= '0;
                    asc_reg <= 1'b1;
                end
                S_OFF_CMP:
                begin
                    if (held_we)
                    begin
                        wr_reg <= wr_reg + SL_W'(1);
                    end
                    idx_reg <= idx_inc;
                end
                S_OFF_END:
                begin
                    held_cnt_reg <= wr_reg[HC_W-1:0];
                end
                S_RB_INIT:
                begin
                    oct_reg     <= '0;
                    idx_reg     <= '0;
                    seq_len_reg <= '0;
                end
                S_RB_GET:
                begin
                    ins_pos_reg <= seq_len_reg;
                    if (cfg.order_mode)
                    begin
                        seq_len_reg <= seq_len_reg + SL_W'(1);
                        if (idx_inc < src_n_reg)
                        begin
                            idx_reg <= idx_inc;
                        end
                        else
                        begin
                            idx_reg <= '0;
                            oct_reg <= oct_reg + 2'd1;
                        end
                    end
                end
                S_INS_CMP:
                begin
                    if (seq_we)
                    begin
                        ins_pos_reg <= ins_prev;
                    end
                end
                S_INS_WR:
                begin
                    seq_len_reg <= seq_len_reg + SL_W'(1);
                    if (idx_inc < src_n_reg)
                    begin
                        idx_reg <= idx_inc;
                    end
                    else
                    begin
                        idx_reg <= '0;
                        oct_reg <= oct_reg + 2'd1;
                    end
                end
                S_RB_END:
                begin
                    if ((op_reg == OP_NOTE_OFF) && (seq_len_reg == '0))
                    begin
                        cur_reg <= -9'sd1;
                        pos_reg <= '0;
                    end
                end
                S_NN_START:
                begin
                    if (seq_len_reg == '0)
                    begin
                        cur_reg <= -9'sd1;
                    end
                end
                S_NN_MOD:
                begin
                    if (mod_reg >= seq_len_reg)
                    begin
                        mod_reg <= mod_reg - seq_len_reg;
                    end
                end
                S_NN_GET:
                begin
                    cur_reg <= $signed({1'b0, seq_rdata});
                    if (cfg.order_mode)
                    begin
                        pos_reg <= ((mod_reg + SL_W'(1)) == seq_len_reg) ? '0
                                                                         : mod_reg + SL_W'(1);
                    end
                    else if (seq_len_reg == SL_W'(1))
                    begin
                        pos_reg <= '0;
                    end
                    else if (asc_reg)
                    begin
                        pos_reg <= pos_reg + SL_W'(1);
                        if ((pos_reg + SL_W'(1)) >= (seq_len_reg - SL_W'(1)))
                        begin
                            asc_reg <= 1'b0;
                        end
                    end
                    else if (pos_reg == '0)
                    begin
                        asc_reg <= 1'b1;
                    end
                    else
                    begin
                        pos_reg <= pos_reg - SL_W'(1);
                        if (pos_reg == SL_W'(1))
                        begin
                            asc_reg <= 1'b1;
                        end
                    end
                end
                default:
                begin
                end
            endcase
        end
    end

    // Output register parts the back end from the result consumer.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if ((state_reg == S_TAIL) && out_free)
        begin
            out_valid_reg <= 1'b1;
        end
        else if (results.ready)
        begin
            out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if ((state_reg == S_TAIL) && out_free)
        begin
            out_beat_reg.active_note <= act;
            out_beat_reg.step_fired  <= fired_reg;
        end
    end

    assign results.valid   = out_valid_reg;
    assign results.payload = out_beat_reg;

    narp_ram #(.WIDTH(7), .DEPTH(NOTE_SLOTS)) u_held_ram (
        .clk   (clk),
        .we    (held_we),
        .waddr (held_waddr),
        .wdata (held_wdata),
        .raddr (held_raddr),
        .rdata (held_rdata)
    );

    narp_ram #(.WIDTH(7), .DEPTH(LATCH_MAX)) u_latch_ram (
        .clk   (clk),
        .we    (latch_we),
        .waddr (latch_waddr),
        .wdata (latch_wdata),
        .raddr (latch_raddr),
        .rdata (latch_rdata)
    );

    narp_ram #(.WIDTH(8), .DEPTH(SEQ_MAX)) u_seq_ram (
        .clk   (clk),
        .we    (seq_we),
        .waddr (seq_waddr),
        .wdata (seq_wdata),
        .raddr (seq_raddr),
        .rdata (seq_rdata)
    );
endmodule

// ===== rtl/note_arpeggiator.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Note arpeggiator
// Held-note and latch lists feeding a sorted or arrival-order step sequence,
// walked by an internal sample clock or by divided MIDI clock.
// ----------------------------------------------------------------------------
//
//  Channel   Direction  Beat fields
//  -------   ---------  -----------------------------------------------
//  notes     in         command[2:0], note_number[6:0]
//  results   out        active_note[8:0] signed, step_fired
//  cfg_*     in         cfg_we, cfg_index[2:0], cfg_data[25:0]
//
// Every input beat gives exactly one result beat. In the back end an item that
// does not step passes the idle, decode and tail states; one that steps also
// runs the next-note states start, modulo, read and get, the modulo state
// subtracting the sequence length as often as needed to wrap the position
// after the sequence has shrunk. Note events cost a scan of the held list,
// reading and comparing each note, and a rebuild: in arrival order each
// sequence entry is read and written; sorted, an insertion sort moves each entry
// past every larger entry before it and writes it at once when it lands at
// the front. Reset is asynchronous and active low and needs no clearing pass.
// A two-beat queue lets the input take up to two beats while the back end is
// busy, and the output register holds a result while the consumer stalls.
// ----------------------------------------------------------------------------
module note_arpeggiator #(
    parameter int NOTE_SLOTS = 64
) (
    input  logic          clk,
    input  logic          rst_n,
    narp_stream_if.sink   notes,
    narp_stream_if.source results,
    input  logic          cfg_we,
    input  logic [2:0]    cfg_index,
    input  logic [25:0]   cfg_data
);
    import narp_pkg::*;

    cfg_t     cfg_reg;
    fe_head_t head;
    logic     pop;

    // Configuration registers; to be written only while the block is idle. The block itself does not enforce this.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.arp_enable   <= 1'b0;
            cfg_reg.latch_on     <= 1'b0;
            cfg_reg.order_mode   <= 1'b0;
            cfg_reg.octave_range <= 2'd0;
            cfg_reg.clock_select <= 3'd0;
            cfg_reg.step_period  <= STEP_PERIOD_RST;
        end
        else if (cfg_we)
        begin
            case (cfg_index)
                CFG_ARP_ENABLE:   cfg_reg.arp_enable   <= cfg_data[0];
                CFG_LATCH_ON:     cfg_reg.latch_on     <= cfg_data[0];
                CFG_ORDER_MODE:   cfg_reg.order_mode   <= cfg_data[0];
                CFG_OCTAVE_RANGE: cfg_reg.octave_range <= cfg_data[1:0];
                CFG_CLOCK_SELECT: cfg_reg.clock_select <= cfg_data[2:0];
                CFG_STEP_PERIOD:  cfg_reg.step_period  <= cfg_data;
                default:
                begin
                end
            endcase
        end
    end

    // The front end decodes commands into queued items.
    narp_front u_front (
        .clk   (clk),
        .rst_n (rst_n),
        .notes (notes),
        .pop   (pop),
        .head  (head)
    );

    // The back end owns the note memories and the step walk.
    narp_back #(.NOTE_SLOTS(NOTE_SLOTS)) u_back (
        .clk     (clk),
        .rst_n   (rst_n),
        .head    (head),
        .pop     (pop),
        .cfg     (cfg_reg),
        .results (results)
    );
endmodule

// ===== tb/note_arpeggiator_tb.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Note arpeggiator testbench
// Drives note, clock and tick beats through the valid/ready input channel and
// checks every result beat against an in-bench model of the arpeggiator,
// over several register settings and several idling and stalling patterns.
// ----------------------------------------------------------------------------
import narp_pkg::*;

// Scoreboard: holds a model of the arpeggiator and the queue of results that
// the accepted beats are due to give.
class arp_scoreboard;
    bit          arp_enable;
    bit          latch_on;
    bit          order_mode;
    bit [1:0]    octave_range;
    bit [2:0]    clock_select;
    int unsigned step_period;

    bit [7:0]    held_notes[64];
    int unsigned held_count;
    bit [7:0]    latch_notes[64];
    int unsigned latch_count;
    bit [7:0]    seq_notes[256];
    int unsigned seq_len;
    int unsigned position;
    bit          going_up;
    int          playing_note;
    int unsigned pulse_count;
    int unsigned accum;

    out_beat_t   due_results[$];
    int          errors;

    function new();
        arp_enable = 0; latch_on = 0; order_mode = 0; octave_range = 0;
        clock_select = 0; step_period = STEP_PERIOD_RST;
        held_count = 0; latch_count = 0; seq_len = 0; position = 0;
        going_up = 1; playing_note = -1; pulse_count = 0; accum = 0;
        errors = 0;
    endfunction

    function void write_reg(logic [2:0] idx, logic [25:0] val);
        case (idx)
            CFG_ARP_ENABLE:   arp_enable   = val[0];
            CFG_LATCH_ON:     latch_on     = val[0];
            CFG_ORDER_MODE:   order_mode   = val[0];
            CFG_OCTAVE_RANGE: octave_range = val[1:0];
            CFG_CLOCK_SELECT: clock_select = val[2:0];
            CFG_STEP_PERIOD:  step_period  = 32'(val);
            default: ;
        endcase
    endfunction

    function void sort_notes(int unsigned n);
        bit [7:0] v;
        int unsigned j;
        for (int unsigned i = 1; i < n; i++)
        begin
            v = seq_notes[i];
            j = i;
            while (j > 0 && seq_notes[j-1] > v)
            begin
                seq_notes[j] = seq_notes[j-1];
                j--;
            end
            seq_notes[j] = v;
        end
    endfunction

    function void rebuild_sequence();
        int unsigned n;
        int unsigned octs;
        n = latch_on ? latch_count : held_count;
        for (int unsigned i = 0; i < n; i++)
            seq_notes[i] = latch_on ? latch_notes[i] : held_notes[i];
        if (!order_mode)
            sort_notes(n);
        seq_len = n;
        if (octave_range != 0 && n != 0)
        begin
            octs = (octave_range == 1) ? 1 : 3;
            for (int unsigned o = 1; o <= octs; o++)
                for (int unsigned i = 0; i < n; i++)
                    seq_notes[o*n+i] = seq_notes[i] + 8'(o*12);
            seq_len = n * (octs + 1);
            if (!order_mode)
                sort_notes(seq_len);
        end
    endfunction

    function int advance_step();
        int note;
        if (seq_len == 0)
            return -1;
        note = seq_notes[position % seq_len];
        if (!order_mode)
        begin
            if (seq_len == 1)
                position = 0;
            else if (going_up)
            begin
                position++;
                if (position >= seq_len - 1)
                    going_up = 0;
            end
            else if (position == 0)
                going_up = 1;
            else
            begin
                position--;
                if (position == 0)
                    going_up = 1;
            end
        end
        else
            position = (position + 1) % seq_len;
        return note;
    endfunction

    // Works out the result of one accepted input beat and queues it.
    function void note_input(in_beat_t b);
        bit        found;
        int unsigned j, per, divisor;
        int        act;
        out_beat_t r;
        r.step_fired = 0;
        case (b.command)
            CMD_NOTE_ON:
            begin
                if (!latch_on)
                begin
                    found = 0;
                    for (int unsigned i = 0; i < held_count; i++)
                        if (held_notes[i] == b.note_number)
                            found = 1;
                    if (!found && held_count < 64)
                        held_notes[held_count++] = b.note_number;
                end
                else if (latch_count < LATCH_MAX)
                    latch_notes[latch_count++] = b.note_number;
                rebuild_sequence();
                position = 0;
                going_up = 1;
            end
            CMD_NOTE_OFF:
                if (!latch_on)
                begin
                    j = 0;
                    for (int unsigned i = 0; i < held_count; i++)
                        if (held_notes[i] != b.note_number)
                            held_notes[j++] = held_notes[i];
                    held_count = j;
                    rebuild_sequence();
                    if (seq_len == 0)
                    begin
                        playing_note = -1;
                        position = 0;
                    end
                end
            CMD_ALL_OFF:
            begin
                held_count = 0; latch_count = 0; seq_len = 0;
                playing_note = -1; position = 0; pulse_count = 0;
            end
            CMD_MIDI_CLOCK:
                if (clock_select >= CLK_SEL_MIDI_3)
                begin
                    divisor = (clock_select == CLK_SEL_MIDI_3) ? 3 :
                              (clock_select == CLK_SEL_MIDI_12) ? 12 : 6;
                    pulse_count = (pulse_count + 1) & 15;
                    if (pulse_count >= divisor)
                    begin
                        pulse_count = 0;
                        playing_note = advance_step();
                    end
                end
            default: ;
        endcase

        if (!arp_enable || seq_len == 0)
            act = -1;
        else if (b.command == CMD_SAMPLE_TICK && clock_select < CLK_SEL_MIDI_3)
        begin
            if (clock_select == CLK_SEL_HALF)
                per = step_period;
            else if (clock_select == CLK_SEL_DOUBLE)
                per = step_period * 4;
            else
                per = step_period * 2;
            if (per < ONE_SAMPLE)
                per = ONE_SAMPLE;
            accum += ONE_SAMPLE;
            if (accum >= per)
            begin
                accum -= per;
                playing_note = advance_step();
                r.step_fired = 1;
            end
            act = playing_note;
        end
        else
            act = playing_note;
        r.active_note = 9'(act);
        due_results.insert(due_results.size(), r);
    endfunction

    function void check_result(out_beat_t got);
        out_beat_t want;
        if (due_results.size() == 0)
        begin
            $display("%0t: result beat with none expected: note %0d fired %0d",
                     $time, got.active_note, got.step_fired);
            errors++;
            return;
        end
        want = due_results.pop_front();
        if (got.active_note !== want.active_note)
        begin
            $display("%0t: active_note expected %0d actual %0d",
                     $time, want.active_note, got.active_note);
            errors++;
        end
        if (got.step_fired !== want.step_fired)
        begin
            $display("%0t: step_fired expected %0d actual %0d",
                     $time, want.step_fired, got.step_fired);
            errors++;
        end
    endfunction

    function int pending();
        return due_results.size();
    endfunction
endclass

module note_arpeggiator_tb;

    localparam int CYCLE_LIMIT = 4000000;

    logic        clk;
    logic        rst_n;
    logic        cfg_we;
    logic [2:0]  cfg_index;
    logic [25:0] cfg_data;

    narp_stream_if #(.payload_t(in_beat_t))  notes_if ();
    narp_stream_if #(.payload_t(out_beat_t)) results_if ();

    note_arpeggiator u_top (
        .clk       (clk),
        .rst_n     (rst_n),
        .notes     (notes_if.sink),
        .results   (results_if.source),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data)
    );

    arp_scoreboard sb = new();

    // Percent of cycles in which the sender idles and the receiver stalls.
    int unsigned send_idle_pct;
    int unsigned recv_stall_pct;
    int unsigned beats_sent;
    int unsigned cycle_count;

    initial
    begin
        clk = 0;
        rst_n = 0;
        cfg_we = 0;
        cfg_index = CFG_ARP_ENABLE;
        cfg_data = 0;
        notes_if.valid = 0;
        notes_if.payload = '0;
        results_if.ready = 0;
        send_idle_pct = 0;
        recv_stall_pct = 0;
        beats_sent = 0;
        cycle_count = 0;
    end

    always #5 clk = ~clk;

    // The receiver stalls at random; a stretch with the percentage at zero
    // keeps ready high throughout.
    always @(posedge clk)
        results_if.ready <= ($urandom_range(99) >= recv_stall_pct);

    // Every result beat is checked at the edge that moves it.
    always @(posedge clk)
        if (rst_n && results_if.valid && results_if.ready)
            sb.check_result(results_if.payload);

    // Watchdog: a hang anywhere ends the run as a failure.
    always @(posedge clk)
    begin
        cycle_count <= cycle_count + 1;
        if (cycle_count > CYCLE_LIMIT)
        begin
            $display("note_arpeggiator_tb NOT OK");
            $finish;
        end
    end

    // Sends one beat. The idle cycles come first, so valid is only lowered in
    // a step where it is not raised again.
    task automatic send_beat(logic [2:0] cmd, logic [6:0] note);
        in_beat_t b;
        b.command = cmd;
        b.note_number = note;
        while ($urandom_range(99) < send_idle_pct)
        begin
            notes_if.valid <= 0;
            @(posedge clk);
        end
        notes_if.valid <= 1;
        notes_if.payload <= b;
        @(posedge clk);
        while (!notes_if.ready)
            @(posedge clk);
        sb.note_input(b);
        beats_sent++;
    endtask

    // Waits until every expected result beat has arrived, plus a margin.
    task automatic drain();
        notes_if.valid <= 0;
        @(posedge clk);
        while (sb.pending() != 0)
            @(posedge clk);
        repeat (20) @(posedge clk);
    endtask

    // Writes all six registers back to back while the block is idle.
    task automatic apply_config(bit en, bit latch, bit order, bit [1:0] oct,
                                bit [2:0] sel, bit [25:0] period);
        logic [25:0] vals[6];
        vals[0] = 26'(en); vals[1] = 26'(latch); vals[2] = 26'(order);
        vals[3] = 26'(oct); vals[4] = 26'(sel); vals[5] = period;
        for (int i = 0; i < 6; i++)
        begin
            cfg_we <= 1;
            cfg_index <= 3'(i);
            cfg_data <= vals[i];
            @(posedge clk);
            sb.write_reg(3'(i), vals[i]);
        end
        cfg_we <= 0;
        @(posedge clk);
    endtask

    // One random beat. Note events mostly use a small pool so that note-offs
    // and duplicates hit held notes; an occasional all-notes-off keeps the
    // lists short, which keeps the sorted rebuilds cheap.
    task automatic random_beat();
        int unsigned pick;
        logic [6:0]  note;
        pick = $urandom_range(99);
        note = ($urandom_range(3) == 0) ? 7'($urandom_range(127))
                                         : 7'($urandom_range(66, 52));
        if (pick < 28)
            send_beat(CMD_NOTE_ON, note);
        else if (pick < 40)
            send_beat(CMD_NOTE_OFF, note);
        else if (pick < 43)
            send_beat(CMD_ALL_OFF, note);
        else if (pick < 60)
            send_beat(CMD_MIDI_CLOCK, note);
        else if (pick < 96)
            send_beat(CMD_SAMPLE_TICK, note);
        else
            send_beat(3'($urandom_range(7)), note);
    endtask

    initial
    begin
        int unsigned phase;
        bit [25:0]   period;
        repeat (5) @(posedge clk);
        rst_n <= 1;
        @(posedge clk);

        // Directed part: a period below one sample, so every tick steps.
        apply_config(1, 0, 0, 0, CLK_SEL_HALF, 26'd256);
        send_beat(CMD_SAMPLE_TICK, 7'd0);
        send_beat(CMD_NOTE_ON, 7'd0);
        send_beat(CMD_NOTE_ON, 7'd127);
        send_beat(CMD_NOTE_ON, 7'd60);
        send_beat(CMD_NOTE_ON, 7'd60);
        repeat (5) send_beat(CMD_SAMPLE_TICK, 7'd0);
        send_beat(CMD_MIDI_CLOCK, 7'd0);
        send_beat(3'd7, 7'd1);
        send_beat(CMD_NOTE_OFF, 7'd127);
        send_beat(CMD_SAMPLE_TICK, 7'd0);
        send_beat(CMD_NOTE_OFF, 7'd5);
        send_beat(CMD_ALL_OFF, 7'd0);
        send_beat(CMD_SAMPLE_TICK, 7'd0);
        drain();

        // Full held list: ascending notes keep the insertion sort short.
        apply_config(1, 0, 0, 0, 3'd0, 26'd600);
        for (int i = 0; i < 66; i++)
            send_beat(CMD_NOTE_ON, 7'(i + 20));
        repeat (4) send_beat(CMD_SAMPLE_TICK, 7'd0);
        send_beat(CMD_ALL_OFF, 7'd0);
        drain();

        // Full latch list with duplicates, in arrival order over MIDI clock.
        apply_config(1, 1, 1, 3, 3'd7, 26'd300);
        for (int i = 0; i < 66; i++)
            send_beat(CMD_NOTE_ON, 7'(100 + (i % 5)));
        repeat (14) send_beat(CMD_MIDI_CLOCK, 7'd0);
        send_beat(CMD_NOTE_OFF, 7'd100);
        send_beat(CMD_ALL_OFF, 7'd0);
        drain();

        // Random part: each phase draws a new setting and an idling pattern.
        phase = 0;
        while (beats_sent < 1350)
        begin
            case (phase % 4)
                0: begin send_idle_pct = 0;  recv_stall_pct = 0;  end
                1: begin send_idle_pct = 61; recv_stall_pct = 0;  end
                2: begin send_idle_pct = 0;  recv_stall_pct = 61; end
                default: begin send_idle_pct = 22; recv_stall_pct = 22; end
            endcase
            if (phase == 3)
                period = 26'h3FFFFFF;
            else if ($urandom_range(3) == 0)
                period = 26'($urandom_range(67108863, 256));
            else
                period = 26'($urandom_range(2048, 256));
            apply_config($urandom_range(7) != 0, 1'($urandom_range(1)),
                         1'($urandom_range(1)), 2'($urandom_range(3)),
                         3'($urandom_range(7)), period);
            for (int i = 0; i < 120; i++)
            begin
                random_beat();
                // Once, the sender holds off until everything has come back.
                if (phase == 5 && i == 60)
                begin
                    notes_if.valid <= 0;
                    @(posedge clk);
                    while (sb.pending() != 0)
                        @(posedge clk);
                end
            end
            send_beat(CMD_ALL_OFF, 7'd0);
            drain();
            phase++;
        end

        repeat (50) @(posedge clk);
        if (sb.errors == 0 && sb.pending() == 0)
            $display("note_arpeggiator_tb OK");
        else
            $display("note_arpeggiator_tb NOT OK");
        $finish;
    end

endmodule
